// ===== src/ghash_accumulator_top_assert.svh =====
// Assertion macros for the checker module of the GHASH accumulator.
`ifndef GHASH_ACCUMULATOR_TOP_ASSERT_SVH
`define GHASH_ACCUMULATOR_TOP_ASSERT_SVH

// Property checked outside reset.
`define GHASH_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ghash assertion failed");

// Property checked at every edge, reset included.
`define GHASH_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("ghash assertion failed");

`endif

// ===== src/ghash_pkg.sv =====
package ghash_pkg;

  localparam int GhashBits  = 128;
  localparam int HalfW      = 64;
  localparam int BlockBytes = GhashBits / 8;
  localparam int ValidW     = 5;
  localparam int CountW     = 61;
  localparam int CfgIdxW    = 1;

  // x^7 + x^2 + x + 1 in plain bit order; the same polynomial as 0xE1 in
  // the reflected GCM order.
  localparam logic [7:0] RedPoly = 8'h87;

  typedef enum logic [1:0] {
    CMD_AAD    = 2'd0,
    CMD_TEXT   = 2'd1,
    CMD_FINISH = 2'd2
  } cmd_e;

  localparam logic [CfgIdxW-1:0] REG_SUBKEY_HIGH = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_SUBKEY_LOW  = 1'd1;

endpackage

// ===== src/ghash_in_if.sv =====
interface ghash_in_if import ghash_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          command;
  logic [HalfW-1:0]    block_high;
  logic [HalfW-1:0]    block_low;
  logic [ValidW-1:0]   valid_bytes;

  modport source (output valid, command, block_high, block_low, valid_bytes, input ready);
  modport sink   (input valid, command, block_high, block_low, valid_bytes, output ready);
endinterface

// ===== src/ghash_out_if.sv =====
interface ghash_out_if import ghash_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [HalfW-1:0] digest_high;
  logic [HalfW-1:0] digest_low;

  modport source (output valid, digest_high, digest_low, input ready);
  modport sink   (input valid, digest_high, digest_low, output ready);
endinterface

// ===== src/ghash_gfmul.sv =====
// GF(2^128) product in GCM bit order: carry-less multiply, then fold the
// upper half back twice with the reduction polynomial.
module ghash_gfmul import ghash_pkg::*; (
  input  logic [GhashBits-1:0] a_i,
  input  logic [GhashBits-1:0] h_i,
  output logic [GhashBits-1:0] p_o
);

  localparam int ProdW = 2 * GhashBits - 1;
  localparam int ExtW  = 3 * GhashBits - 2;
  localparam int RedW  = $bits(RedPoly) - 1;
  localparam int FoldW = GhashBits + RedW;

  logic [GhashBits-1:0]   a_rev;
  logic [ExtW-1:0]        h_ext;
  logic [ProdW-1:0]       prod;
  logic [GhashBits-2:0]   prod_hi;
  logic [FoldW-1:0]       fold1;
  logic [RedW-1:0]        over;
  logic [GhashBits-1:0]   fold2;

  // GCM bit 0 is the MSB; reversing a gives plain polynomial order, while
  // h in GCM order already runs the window the right way.
  always_comb begin
    for (int i = 0; i < GhashBits; i++) begin
      a_rev[i] = a_i[GhashBits-1-i];
    end
  end

  assign h_ext = {{(GhashBits-1){1'b0}}, h_i, {(GhashBits-1){1'b0}}};

  always_comb begin
    for (int k = 0; k < ProdW; k++) begin
      prod[k] = ^(a_rev & h_ext[ProdW-1-k +: GhashBits]);
    end
  end

  assign prod_hi = prod[ProdW-1:GhashBits];

  always_comb begin
    fold1 = {{RedW{1'b0}}, prod[GhashBits-1:0]};
    for (int k = 0; k <= RedW; k++) begin
      if (RedPoly[k]) begin
        fold1 = fold1 ^ (FoldW'(prod_hi) << k);
      end
    end
  end

  assign over = fold1[FoldW-1:GhashBits];

  always_comb begin
    fold2 = fold1[GhashBits-1:0];
    for (int k = 0; k <= RedW; k++) begin
      if (RedPoly[k]) begin
        fold2 = fold2 ^ (GhashBits'(over) << k);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < GhashBits; i++) begin
      p_o[GhashBits-1-i] = fold2[i];
    end
  end

endmodule

// ===== src/ghash_accumulator_top.sv =====
// GHASH accumulator for GCM. Each transaction on in_i carries one 128-bit
// block tagged as associated data or ciphertext (only the leading
// valid_bytes bytes count), or a finish command. The block is XORed into the
// accumulator, which is multiplied by the hash subkey H written through the
// cfg port; finish absorbs the length block, sends the digest on out_o and
// clears accumulator and byte counts. One transaction is taken every cycle,
// except while a finish waits on a stalled out_o; the accumulator update is
// a combinational GF(2^128) multiply feeding back into its own register,
// behind one input register. A finish moves from the input register and
// its digest is registered onto out_o once out_o is free.
// Write H only while no transaction is in flight.
module ghash_accumulator_top import ghash_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [HalfW-1:0]   cfg_data_i,
  ghash_in_if.sink           in_i,
  ghash_out_if.source        out_o
);

  logic [GhashBits-1:0] subkey_q;
  logic                 in_vld_q;
  cmd_e                 cmd_q;
  logic [GhashBits-1:0] blk_q;
  logic [ValidW-1:0]    nb_q;
  logic [GhashBits-1:0] acc_q, acc_d;
  logic [CountW-1:0]    aad_cnt_q, aad_cnt_d;
  logic [CountW-1:0]    text_cnt_q, text_cnt_d;
  logic                 out_vld_q;
  logic [GhashBits-1:0] digest_q;

  logic                 is_abs;
  logic                 is_fin;
  logic [ValidW-1:0]    nsat;
  logic [GhashBits-1:0] mask;
  logic [GhashBits-1:0] mul_a;
  logic [GhashBits-1:0] prod;
  logic                 out_free;
  logic                 adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      subkey_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_SUBKEY_HIGH: subkey_q[GhashBits-1:HalfW] <= cfg_data_i;
        REG_SUBKEY_LOW:  subkey_q[HalfW-1:0] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    is_abs = 1'b0;
    is_fin = 1'b0;
    case (cmd_q)
      CMD_AAD, CMD_TEXT: is_abs = (nb_q != '0);
      CMD_FINISH:        is_fin = 1'b1;
      default: ;
    endcase
  end

  assign nsat = (nb_q > ValidW'(BlockBytes)) ? ValidW'(BlockBytes) : nb_q;

  always_comb begin
    for (int b = 0; b < BlockBytes; b++) begin
      mask[GhashBits-1-8*b -: 8] = (ValidW'(b) < nsat) ? 8'hff : 8'h00;
    end
  end

  assign mul_a = acc_q ^ (is_fin ? {aad_cnt_q, 3'b000, text_cnt_q, 3'b000} : (blk_q & mask));

  ghash_gfmul u_gfmul (
    .a_i (mul_a),
    .h_i (subkey_q),
    .p_o (prod)
  );

  // A finish needs the result register; everything else always moves on.
  assign out_free   = !out_vld_q || out_o.ready;
  assign adv        = in_vld_q && (!is_fin || out_free);
  assign in_i.ready = !in_vld_q || adv;

  always_comb begin
    acc_d      = acc_q;
    aad_cnt_d  = aad_cnt_q;
    text_cnt_d = text_cnt_q;
    if (adv && is_abs) begin
      acc_d = prod;
      if (cmd_q == CMD_AAD) begin
        aad_cnt_d = aad_cnt_q + CountW'(nsat);
      end else begin
        text_cnt_d = text_cnt_q + CountW'(nsat);
      end
    end else if (adv && is_fin) begin
      acc_d      = '0;
      aad_cnt_d  = '0;
      text_cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      cmd_q      <= CMD_AAD;
      acc_q      <= '0;
      aad_cnt_q  <= '0;
      text_cnt_q <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
        cmd_q    <= cmd_e'(in_i.command);
      end
      acc_q      <= acc_d;
      aad_cnt_q  <= aad_cnt_d;
      text_cnt_q <= text_cnt_d;
      if (adv && is_fin) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      blk_q <= {in_i.block_high, in_i.block_low};
      nb_q  <= in_i.valid_bytes;
    end
    if (adv && is_fin) begin
      digest_q <= prod;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.digest_high = digest_q[GhashBits-1:HalfW];
  assign out_o.digest_low  = digest_q[HalfW-1:0];

endmodule

// ===== src/ghash_accumulator_chk.sv =====
`include "ghash_accumulator_top_assert.svh"

module ghash_accumulator_chk import ghash_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid,
  input logic             in_ready,
  input logic [1:0]       in_command,
  input logic             out_valid,
  input logic             out_ready,
  input logic [HalfW-1:0] out_digest_high,
  input logic [HalfW-1:0] out_digest_low
);

  // A stalled digest stays put.
  `GHASH_ASSERT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready |=> out_valid)
  `GHASH_ASSERT(a_out_stable, clk_i, rst_ni,
                out_valid && !out_ready |=> $stable(out_digest_high) && $stable(out_digest_low))

  // A finish waiting on a stalled result register blocks new transactions.
  `GHASH_ASSERT(a_fin_backpressure, clk_i, rst_ni,
                (in_valid && in_ready && in_command == CMD_FINISH) ##1
                (out_valid && !out_ready) |-> !in_ready)

  // No digest is offered while in reset.
  `GHASH_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !out_valid)

endmodule

bind ghash_accumulator_top ghash_accumulator_chk u_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid        (in_i.valid),
  .in_ready        (in_i.ready),
  .in_command      (in_i.command),
  .out_valid       (out_o.valid),
  .out_ready       (out_o.ready),
  .out_digest_high (out_o.digest_high),
  .out_digest_low  (out_o.digest_low)
);

// ===== tb/ghash_accumulator_top_tb.sv =====
module ghash_accumulator_top_tb;
  import ghash_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]   CMD_UNUSED  = 2'd3;
  localparam logic [127:0] GcmReduce   = {8'hE1, 120'd0};
  localparam int           DrainCycles = 8;
  localparam int           MaxReported = 10;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct packed {
    logic [HalfW-1:0] dig_high;
    logic [HalfW-1:0] dig_low;
  } digest_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [HalfW-1:0]   cfg_data_i;

  ghash_in_if  in_if ();
  ghash_out_if out_if ();

  ghash_accumulator_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // Predicted block state
  logic [127:0]        h_key      = '0;
  logic [127:0]        acc_state  = '0;
  logic [CountW-1:0]   aad_bytes  = '0;
  logic [CountW-1:0]   text_bytes = '0;
  digest_t             digest_q[$];

  idle_mode_e  idle_mode       = IDLE_NONE;
  int unsigned hold_req        = 0;
  int unsigned hold_cnt        = 0;
  int unsigned items_sent      = 0;
  int unsigned digests_checked = 0;
  int unsigned subkey_settings = 0;
  int unsigned mismatches      = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_index_i       = REG_SUBKEY_HIGH;
    cfg_data_i        = '0;
    in_if.valid       = 1'b0;
    in_if.command     = CMD_AAD;
    in_if.block_high  = '0;
    in_if.block_low   = '0;
    in_if.valid_bytes = '0;
    out_if.ready      = 1'b0;
  end

  // GCM multiply: bit 127 of the vector is coefficient x^0.
  function automatic logic [127:0] gf128_mul(logic [127:0] x, logic [127:0] y);
    logic [127:0] z = '0;
    logic [127:0] v = y;
    for (int i = 0; i < 128; i++) begin
      if (x[127-i]) z ^= v;
      v = v[0] ? ((v >> 1) ^ GcmReduce) : (v >> 1);
    end
    return z;
  endfunction

  task automatic predict_ghash(logic [1:0] cmd, logic [HalfW-1:0] blk_hi,
                               logic [HalfW-1:0] blk_lo, logic [ValidW-1:0] nbytes);
    int unsigned  n;
    logic [127:0] mask;
    digest_t      d;
    n = nbytes;
    if (cmd == CMD_AAD || cmd == CMD_TEXT) begin
      if (n != 0) begin
        if (n > BlockBytes) n = BlockBytes;
        mask      = ~128'd0 << (128 - 8 * n);
        acc_state = gf128_mul(acc_state ^ ({blk_hi, blk_lo} & mask), h_key);
        if (cmd == CMD_AAD) aad_bytes += n;
        else text_bytes += n;
      end
    end else if (cmd == CMD_FINISH) begin
      acc_state  = gf128_mul(acc_state ^ {aad_bytes, 3'b000, text_bytes, 3'b000}, h_key);
      d.dig_high = acc_state[127:64];
      d.dig_low  = acc_state[63:0];
      digest_q.push_back(d);
      acc_state  = '0;
      aad_bytes  = '0;
      text_bytes = '0;
    end
  endtask

  function automatic logic [HalfW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic bit sender_idles();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(99) < 66;
      IDLE_BOTH:   return $urandom_range(99) < 8;
      default:     return 1'b0;
    endcase
  endfunction

  // Entered and left at a falling edge; valid stays high after the transaction.
  task automatic send_item(logic [1:0] cmd, logic [HalfW-1:0] blk_hi,
                           logic [HalfW-1:0] blk_lo, logic [ValidW-1:0] nbytes);
    while (sender_idles()) begin
      in_if.valid      <= 1'b0;
      in_if.block_high <= rand64();
      @(negedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.command     <= cmd;
    in_if.block_high  <= blk_hi;
    in_if.block_low   <= blk_lo;
    in_if.valid_bytes <= nbytes;
    do @(posedge clk_i); while (!in_if.ready);
    predict_ghash(cmd, blk_hi, blk_lo, nbytes);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Leaves the write enable high; the caller drops it after the last write.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [HalfW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    if (idx == REG_SUBKEY_HIGH) h_key[127:64] = data;
    else h_key[63:0] = data;
  endtask

  task automatic set_subkey(logic [127:0] h);
    wait_idle();
    write_reg(REG_SUBKEY_HIGH, h[127:64]);
    write_reg(REG_SUBKEY_LOW, h[63:0]);
    cfg_we_i <= 1'b0;
    subkey_settings++;
  endtask

  task automatic send_noise();
    case ($urandom_range(3))
      0: send_item(CMD_UNUSED, rand64(), rand64(), ValidW'($urandom));
      1: send_item($urandom_range(1) ? CMD_TEXT : CMD_AAD, rand64(), rand64(), '0);
      2: send_item($urandom_range(1) ? CMD_TEXT : CMD_AAD, rand64(), rand64(),
                   ValidW'($urandom_range(17, 31)));
      default: send_item(CMD_AAD, rand64(), rand64(), ValidW'($urandom_range(1, 16)));
    endcase
  endtask

  function automatic logic [ValidW-1:0] tail_bytes();
    return ($urandom_range(2) == 0) ? ValidW'($urandom_range(1, 15)) : ValidW'(BlockBytes);
  endfunction

  // Associated data, then ciphertext, each ending in a possibly partial block.
  task automatic send_message(int unsigned max_aad, int unsigned max_text);
    int unsigned naad;
    int unsigned ntext;
    naad  = $urandom_range(max_aad);
    ntext = $urandom_range(max_text);
    for (int i = 0; i < naad; i++) begin
      if ($urandom_range(99) < 6) send_noise();
      send_item(CMD_AAD, rand64(), rand64(),
                (i == naad - 1) ? tail_bytes() : ValidW'(BlockBytes));
    end
    for (int i = 0; i < ntext; i++) begin
      if ($urandom_range(99) < 6) send_noise();
      send_item(CMD_TEXT, rand64(), rand64(),
                (i == ntext - 1) ? tail_bytes() : ValidW'(BlockBytes));
    end
    send_item(CMD_FINISH, rand64(), rand64(), ValidW'($urandom));
  endtask

  // Receiver: long hold-off when requested, otherwise stall per idle mode.
  always @(negedge clk_i) begin
    if (hold_req != 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (hold_cnt != 0) begin
      hold_cnt--;
      out_if.ready <= 1'b0;
    end else begin
      case (idle_mode)
        IDLE_RECEIVER: out_if.ready <= $urandom_range(99) >= 66;
        IDLE_BOTH:     out_if.ready <= $urandom_range(99) >= 8;
        default:       out_if.ready <= 1'b1;
      endcase
    end
  end

  task automatic flag_mismatch(string what, logic [HalfW-1:0] exp_v, logic [HalfW-1:0] act_v);
    mismatches++;
    if (mismatches <= MaxReported)
      $display("%0t: %s mismatch: expected %016h, got %016h", $realtime, what, exp_v, act_v);
  endtask

  always @(posedge clk_i) begin
    digest_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (digest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReported)
          $display("%0t: unexpected digest %016h_%016h", $realtime,
                   out_if.digest_high, out_if.digest_low);
      end else begin
        want = digest_q.pop_front();
        digests_checked++;
        if (out_if.digest_high !== want.dig_high)
          flag_mismatch("digest_high", want.dig_high, out_if.digest_high);
        if (out_if.digest_low !== want.dig_low)
          flag_mismatch("digest_low", want.dig_low, out_if.digest_low);
      end
    end
  end

  // Subkey still at reset: every digest is zero.
  task automatic test_reset_subkey();
    send_item(CMD_AAD, rand64(), rand64(), ValidW'(BlockBytes));
    send_item(CMD_TEXT, rand64(), rand64(), 5'd7);
    send_item(CMD_FINISH, '0, '0, '0);
    wait_idle();
  endtask

  task automatic test_directed();
    set_subkey(128'h66e94bd4ef8a2c3b884cfa59ca342b2e);
    send_item(CMD_AAD, '1, '1, ValidW'(BlockBytes));
    send_item(CMD_AAD, '0, '0, ValidW'(BlockBytes));
    send_item(CMD_AAD, rand64(), rand64(), 5'd1);
    send_item(CMD_TEXT, rand64(), rand64(), 5'd15);
    send_item(CMD_TEXT, '1, '1, 5'd8);
    send_item(CMD_TEXT, '1, '1, 5'd9);
    // class switch in mid message, absorbed in arrival order
    send_item(CMD_AAD, rand64(), rand64(), 5'd3);
    send_item(CMD_AAD, '1, '1, '0);
    send_item(CMD_TEXT, rand64(), rand64(), 5'd17);
    send_item(CMD_TEXT, '1, '1, 5'd31);
    send_item(CMD_UNUSED, '1, '1, 5'd31);
    send_item(CMD_FINISH, '1, '1, 5'd31);
    // empty message, back to back finishes
    send_item(CMD_FINISH, '0, '0, '0);
    send_item(CMD_FINISH, rand64(), rand64(), 5'd16);
    // non-96-bit IV absorbed as ciphertext
    send_item(CMD_TEXT, rand64(), rand64(), ValidW'(BlockBytes));
    send_item(CMD_TEXT, rand64(), rand64(), 5'd4);
    send_item(CMD_FINISH, '0, '0, '0);
    wait_idle();
  endtask

  task automatic test_subkey_extremes();
    logic [127:0] keys[5];
    keys = '{'1, 128'd1, {1'b1, 127'd0}, '0, {rand64(), rand64()}};
    foreach (keys[k]) begin
      set_subkey(keys[k]);
      send_item(CMD_AAD, '1, '1, ValidW'(BlockBytes));
      send_item(CMD_TEXT, rand64(), rand64(), 5'd11);
      send_item(CMD_FINISH, '0, '0, '0);
    end
    wait_idle();
  endtask

  // Hold the digest side off so the block fills and stalls its input.
  task automatic test_backpressure();
    set_subkey({rand64(), rand64()});
    idle_mode = IDLE_NONE;
    hold_req  = 400;
    repeat (60) begin
      send_item(CMD_AAD, rand64(), rand64(), ValidW'(BlockBytes));
      send_item(CMD_FINISH, rand64(), rand64(), ValidW'($urandom));
    end
    wait_idle();
  endtask

  task automatic test_drain_pause();
    idle_mode = IDLE_RECEIVER;
    repeat (10) begin
      send_message(2, 2);
      in_if.valid <= 1'b0;
      while (digest_q.size() != 0) @(posedge clk_i);
      @(negedge clk_i);
    end
    wait_idle();
  endtask

  task automatic test_random();
    idle_mode_e  modes[4];
    int unsigned start;
    modes = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};
    foreach (modes[m]) begin
      set_subkey((m == 1) ? '1 : {rand64(), rand64()});
      idle_mode = modes[m];
      start     = items_sent;
      while (items_sent - start < 250) send_message(3, 4);
      wait_idle();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_subkey();
    test_directed();
    test_subkey_extremes();
    test_backpressure();
    test_drain_pause();
    test_random();
    $display("Ran %0d transactions under %0d subkey settings and four idle patterns,",
             items_sent, subkey_settings);
    $display("with a long output hold-off; %0d digests compared, %0d mismatches.",
             digests_checked, mismatches);
    if (mismatches == 0 && digest_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout with %0d digests outstanding", digest_q.size());
    $display("Verification failed");
    $finish;
  end

endmodule
